// File: rtl/bmma_pkg.sv
// package: sizes, codes, state and struct types of the block matrix multiply-accumulate
`timescale 1ns / 1ps
package bmma_pkg;

  // block shape
  localparam int BLOCK_ROWS  = 8;
  localparam int BLOCK_COLS  = 8;
  localparam int BLOCK_DEPTH = 64;

  localparam int CELLS  = BLOCK_ROWS * BLOCK_COLS;
  localparam int ROW_W  = $clog2(BLOCK_ROWS);
  localparam int COL_W  = $clog2(BLOCK_COLS);
  localparam int K_W    = $clog2(BLOCK_DEPTH);
  localparam int CELL_W = $clog2(CELLS);
  localparam int A_AW   = $clog2(BLOCK_ROWS * BLOCK_DEPTH);
  localparam int B_AW   = $clog2(BLOCK_COLS * BLOCK_DEPTH);

  // field widths
  localparam int OP_W   = 3;
  localparam int FI_W   = 3;
  localparam int SI_W   = 6;
  localparam int OPND_W = 16;
  localparam int C_W    = 48;
  localparam int MODE_W = 2;
  localparam int BETA_W = 16;

  // datapath widths
  localparam int PROD_W      = 2 * OPND_W;
  localparam int CPROD_W     = C_W + BETA_W;
  localparam int ACC_W       = 52;
  localparam int ROUND_SHIFT = 14;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

  // register port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_SEL_BIT = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_A = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_C = 3'd2;
  localparam logic [OP_W-1:0] OP_RUN     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

  // beta modes, anything above keep scales
  localparam logic [MODE_W-1:0] BETA_ZERO  = 2'd0;
  localparam logic [MODE_W-1:0] BETA_KEEP  = 2'd1;
  localparam logic [MODE_W-1:0] BETA_SCALE = 2'd2;

  localparam logic [BETA_W-1:0] BETA_ONE = 16'sd16384;

  // register indexes
  localparam logic REG_BETA_MODE  = 1'b0;
  localparam logic REG_BETA_VALUE = 1'b1;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_READ
  } state_t;

  typedef struct packed {
    logic              a_en;
    logic              b_en;
    logic [A_AW-1:0]   a_addr;
    logic [B_AW-1:0]   b_addr;
    logic [OPND_W-1:0] data;
  } ab_wr_t;

  typedef struct packed {
    logic            en;
    logic [A_AW-1:0] a_addr;
    logic [B_AW-1:0] b_addr;
  } ab_rd_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [C_W-1:0]    value;
    logic              mark;
  } c_wr_t;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [CELL_W-1:0] idx;
  } mac_tag_t;

endpackage

// File: rtl/block_matrix_multiply_accumulate.sv
// top level: register port, request sequencer, stores and multiply-accumulate pipeline
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------------
//  request  | in_valid / in_stall    | operation, first_index, second_index, operand,
//           |                        | acc_value
//  result   | out_valid / out_stall  | result_kind, result_value, saturated
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready (always high)
//
//  write requests go straight to the stores; a read of C passes the memory read register, then
//  the result register; a run issues one A/B read pair and one multiply-accumulate per cycle
//  over every i, j and k, then waits for the multiply-accumulate pipeline to drain
//  reset loads beta_mode = scale and beta_value = 1.0 and clears the saturation marks;
//  there is no clearing pass over the memories
//  a run or read request stalls while an earlier result is still held in the result register
`timescale 1ns / 1ps
module block_matrix_multiply_accumulate (
  input  logic                               clk,
  input  logic                               rst,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bmma_pkg::ADDR_W-1:0]        paddr,
  input  logic [bmma_pkg::DATA_W-1:0]        pwdata,
  output logic [bmma_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bmma_pkg::OP_W-1:0]          operation,
  input  logic [bmma_pkg::FI_W-1:0]          first_index,
  input  logic [bmma_pkg::SI_W-1:0]          second_index,
  input  logic signed [bmma_pkg::OPND_W-1:0] operand,
  input  logic signed [bmma_pkg::C_W-1:0]    acc_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               result_kind,
  output logic signed [bmma_pkg::C_W-1:0]    result_value,
  output logic                               saturated
);

  bmma_pkg::state_t state, state_next;

  // configuration registers
  logic [bmma_pkg::MODE_W-1:0] beta_mode;
  logic [bmma_pkg::BETA_W-1:0] beta_value;
  logic                        cfg_write;
  logic                        reg_sel;

  // request decode
  logic in_accept, wants_result, run_start, read_start;
  logic a_ok, b_ok, c_ok;
  logic [bmma_pkg::CELL_W-1:0] in_cell;

  // run sequencer
  logic [bmma_pkg::ROW_W-1:0]  i_cnt;
  logic [bmma_pkg::COL_W-1:0]  j_cnt;
  logic [bmma_pkg::K_W-1:0]    k_cnt;
  logic [bmma_pkg::CELL_W-1:0] cell_cnt;
  logic k_last, j_last, i_last, issue_last;
  logic issue_en, run_end, run_done, read_load;
  logic any_sat, rd_ok;

  // store and pipeline connections
  bmma_pkg::ab_wr_t   ab_wr;
  bmma_pkg::ab_rd_t   ab_rd;
  bmma_pkg::c_wr_t    in_c_wr, run_c_wr, c_wr;
  bmma_pkg::mac_tag_t tag;
  logic                        c_rd_en;
  logic [bmma_pkg::CELL_W-1:0] c_rd_addr;
  logic [bmma_pkg::C_W-1:0]    c_q_value;
  logic                        c_q_mark;
  logic [bmma_pkg::OPND_W-1:0] a_q, b_q;
  logic                        wb_sat;

  // ---------------- register port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[bmma_pkg::REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_mode  <= bmma_pkg::BETA_SCALE;
      beta_value <= bmma_pkg::BETA_ONE;
    end else if (cfg_write) begin
      unique case (reg_sel)
        bmma_pkg::REG_BETA_MODE:  beta_mode  <= pwdata[bmma_pkg::MODE_W-1:0];
        bmma_pkg::REG_BETA_VALUE: beta_value <= pwdata[bmma_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bmma_pkg::REG_BETA_MODE:
        prdata = {{(bmma_pkg::DATA_W-bmma_pkg::MODE_W){1'b0}}, beta_mode};
      bmma_pkg::REG_BETA_VALUE:
        prdata = {{(bmma_pkg::DATA_W-bmma_pkg::BETA_W){1'b0}}, beta_value};
      default:
        prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  // run and read need the result register; writes go straight to the stores
  assign wants_result = (operation == bmma_pkg::OP_RUN) || (operation == bmma_pkg::OP_READ_C);
  assign in_stall     = (state != bmma_pkg::ST_IDLE) || (out_valid && out_stall && wants_result);
  assign in_accept    = in_valid && !in_stall;
  assign run_start    = in_accept && (operation == bmma_pkg::OP_RUN);
  assign read_start   = in_accept && (operation == bmma_pkg::OP_READ_C);

  assign a_ok = (int'(first_index) < bmma_pkg::BLOCK_ROWS)
             && (int'(second_index) < bmma_pkg::BLOCK_DEPTH);
  assign b_ok = (int'(first_index) < bmma_pkg::BLOCK_COLS)
             && (int'(second_index) < bmma_pkg::BLOCK_DEPTH);
  assign c_ok = (int'(first_index) < bmma_pkg::BLOCK_ROWS)
             && (int'(second_index) < bmma_pkg::BLOCK_COLS);

  assign in_cell = bmma_pkg::CELL_W'(first_index) * bmma_pkg::CELL_W'(bmma_pkg::BLOCK_COLS)
                 + bmma_pkg::CELL_W'(second_index);

  always_comb begin
    ab_wr.a_en   = in_accept && (operation == bmma_pkg::OP_WRITE_A) && a_ok;
    ab_wr.b_en   = in_accept && (operation == bmma_pkg::OP_WRITE_B) && b_ok;
    ab_wr.a_addr = bmma_pkg::A_AW'(first_index) * bmma_pkg::A_AW'(bmma_pkg::BLOCK_DEPTH)
                 + bmma_pkg::A_AW'(second_index);
    ab_wr.b_addr = bmma_pkg::B_AW'(first_index) * bmma_pkg::B_AW'(bmma_pkg::BLOCK_DEPTH)
                 + bmma_pkg::B_AW'(second_index);
    ab_wr.data   = operand;
  end

  // writing a C entry clears its mark
  always_comb begin
    in_c_wr.en    = in_accept && (operation == bmma_pkg::OP_WRITE_C) && c_ok;
    in_c_wr.addr  = in_cell;
    in_c_wr.value = acc_value;
    in_c_wr.mark  = 1'b0;
  end

  // run writeback and request writes never share a cycle
  assign c_wr = run_c_wr.en ? run_c_wr : in_c_wr;

  // ---------------- run sequencer ----------------
  // walk i, j, k with k innermost; one cell of C per full sweep of k
  assign k_last     = (k_cnt == bmma_pkg::K_W'(bmma_pkg::BLOCK_DEPTH - 1));
  assign j_last     = (j_cnt == bmma_pkg::COL_W'(bmma_pkg::BLOCK_COLS - 1));
  assign i_last     = (i_cnt == bmma_pkg::ROW_W'(bmma_pkg::BLOCK_ROWS - 1));
  assign issue_last = issue_en && k_last && j_last && i_last;
  assign run_end    = run_c_wr.en && (run_c_wr.addr == bmma_pkg::CELL_W'(bmma_pkg::CELLS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      bmma_pkg::ST_IDLE: begin
        if (run_start) begin
          state_next = bmma_pkg::ST_ISSUE;
        end else if (read_start) begin
          state_next = bmma_pkg::ST_READ;
        end
      end
      bmma_pkg::ST_ISSUE: begin
        if (issue_last) begin
          state_next = bmma_pkg::ST_DRAIN;
        end
      end
      bmma_pkg::ST_DRAIN: begin
        if (run_end) begin
          state_next = bmma_pkg::ST_IDLE;
        end
      end
      bmma_pkg::ST_READ: begin
        state_next = bmma_pkg::ST_IDLE;
      end
      default: begin
        state_next = bmma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    issue_en  = 1'b0;
    run_done  = 1'b0;
    read_load = 1'b0;
    unique case (state)
      bmma_pkg::ST_IDLE:  ;
      bmma_pkg::ST_ISSUE: issue_en  = 1'b1;
      bmma_pkg::ST_DRAIN: run_done  = run_end;
      bmma_pkg::ST_READ:  read_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      cell_cnt <= '0;
    end else if (run_start) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      cell_cnt <= '0;
    end else if (issue_en) begin
      if (k_last) begin
        k_cnt    <= '0;
        cell_cnt <= issue_last ? '0 : cell_cnt + 1'b1;
        if (j_last) begin
          j_cnt <= '0;
          i_cnt <= i_last ? '0 : i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end else begin
        k_cnt <= k_cnt + 1'b1;
      end
    end
  end

  // operand reads for A[i][k] and B[j][k]
  always_comb begin
    ab_rd.en     = issue_en;
    ab_rd.a_addr = bmma_pkg::A_AW'(i_cnt) * bmma_pkg::A_AW'(bmma_pkg::BLOCK_DEPTH)
                 + bmma_pkg::A_AW'(k_cnt);
    ab_rd.b_addr = bmma_pkg::B_AW'(j_cnt) * bmma_pkg::B_AW'(bmma_pkg::BLOCK_DEPTH)
                 + bmma_pkg::B_AW'(k_cnt);
  end

  // C of a cell is read once at its first k, long before its own writeback
  assign c_rd_en   = (issue_en && (k_cnt == '0)) || read_start;
  assign c_rd_addr = issue_en ? cell_cnt : in_cell;

  always_comb begin
    tag.valid = issue_en;
    tag.first = (k_cnt == '0);
    tag.last  = k_last;
    tag.idx   = cell_cnt;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      any_sat <= 1'b0;
    end else if (run_start) begin
      any_sat <= 1'b0;
    end else if (wb_sat) begin
      any_sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (read_start) begin
      rd_ok <= c_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run_done || read_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_done) begin
      result_kind  <= bmma_pkg::KIND_RUN;
      result_value <= '0;
      saturated    <= any_sat | wb_sat;
    end else if (read_load) begin
      result_kind  <= bmma_pkg::KIND_READ;
      result_value <= rd_ok ? c_q_value : '0;
      saturated    <= rd_ok & c_q_mark;
    end
  end

  // ---------------- datapath ----------------
  bmma_ab_store u_ab_store (
    .clk (clk),
    .wr  (ab_wr),
    .rd  (ab_rd),
    .a_q (a_q),
    .b_q (b_q)
  );

  bmma_c_store u_c_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (c_wr),
    .rd_en   (c_rd_en),
    .rd_addr (c_rd_addr),
    .q_value (c_q_value),
    .q_mark  (c_q_mark)
  );

  bmma_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .tag_in     (tag),
    .a_q        (a_q),
    .b_q        (b_q),
    .c_q        (c_q_value),
    .c_mark_q   (c_q_mark),
    .beta_mode  (beta_mode),
    .beta_value (beta_value),
    .wb         (run_c_wr),
    .wb_sat     (wb_sat)
  );

`ifndef SYNTH
  // requests are only taken between runs and reads
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == bmma_pkg::ST_IDLE))
    else $error("request accepted while busy");

  // the result register stays free for the whole run
  a_out_free_run: assert property (@(posedge clk) disable iff (rst)
    (state == bmma_pkg::ST_ISSUE || state == bmma_pkg::ST_DRAIN) |-> !out_valid)
    else $error("result pending during run");

  // a new result only comes from a run end or a read
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bmma_pkg::ST_DRAIN
                       || $past(state) == bmma_pkg::ST_READ))
    else $error("result without run or read");

  // pipeline writebacks only happen inside a run
  a_wb_in_run: assert property (@(posedge clk) disable iff (rst)
    run_c_wr.en |-> (state == bmma_pkg::ST_ISSUE || state == bmma_pkg::ST_DRAIN))
    else $error("writeback outside run");
`endif

endmodule

// File: rtl/bmma_ab_store.sv
// A and B operand memories, one write port and one registered read port each
`timescale 1ns / 1ps
module bmma_ab_store (
  input  logic                         clk,
  input  bmma_pkg::ab_wr_t             wr,
  input  bmma_pkg::ab_rd_t             rd,
  output logic [bmma_pkg::OPND_W-1:0]  a_q,
  output logic [bmma_pkg::OPND_W-1:0]  b_q
);

  logic [bmma_pkg::OPND_W-1:0] a_mem [bmma_pkg::BLOCK_ROWS * bmma_pkg::BLOCK_DEPTH];
  logic [bmma_pkg::OPND_W-1:0] b_mem [bmma_pkg::BLOCK_COLS * bmma_pkg::BLOCK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.a_en) begin
      a_mem[wr.a_addr] <= wr.data;
    end
    if (rd.en) begin
      a_q <= a_mem[rd.a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.b_en) begin
      b_mem[wr.b_addr] <= wr.data;
    end
    if (rd.en) begin
      b_q <= b_mem[rd.b_addr];
    end
  end

endmodule

// File: rtl/bmma_c_store.sv
// C accumulator memory with saturation mark per entry and written flags
`timescale 1ns / 1ps
module bmma_c_store (
  input  logic                         clk,
  input  logic                         rst,
  input  bmma_pkg::c_wr_t              wr,
  input  logic                         rd_en,
  input  logic [bmma_pkg::CELL_W-1:0]  rd_addr,
  output logic [bmma_pkg::C_W-1:0]     q_value,
  output logic                         q_mark
);

  // word is {mark, value}
  logic [bmma_pkg::C_W:0]      mem [bmma_pkg::CELLS];
  logic [bmma_pkg::CELLS-1:0]  written;
  logic [bmma_pkg::C_W:0]      q_word;
  logic                        q_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.mark, wr.value};
    end
    if (rd_en) begin
      q_word    <= mem[rd_addr];
      q_written <= written[rd_addr];
    end
  end

  // marks of never written entries read as clear
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  assign q_value = q_word[bmma_pkg::C_W-1:0];
  assign q_mark  = q_word[bmma_pkg::C_W] & q_written;

endmodule

// File: rtl/bmma_mac.sv
// multiply-accumulate pipeline: product, beta scaling, accumulate, saturate
`timescale 1ns / 1ps
module bmma_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  bmma_pkg::mac_tag_t           tag_in,
  input  logic [bmma_pkg::OPND_W-1:0]  a_q,
  input  logic [bmma_pkg::OPND_W-1:0]  b_q,
  input  logic [bmma_pkg::C_W-1:0]     c_q,
  input  logic                         c_mark_q,
  input  logic [bmma_pkg::MODE_W-1:0]  beta_mode,
  input  logic [bmma_pkg::BETA_W-1:0]  beta_value,
  output bmma_pkg::c_wr_t              wb,
  output logic                         wb_sat
);

  bmma_pkg::mac_tag_t s1_tag, s2_tag, s3_tag;
  logic                          s4_valid;
  logic [bmma_pkg::CELL_W-1:0]   s4_cell;
  logic [bmma_pkg::PROD_W-1:0]   prod2, prod3;
  logic [bmma_pkg::CPROD_W-1:0]  cprod2, round_sum, scaled;
  logic [bmma_pkg::C_W-1:0]      c2;
  logic                          mark2, mark3, mark_hold;
  logic [bmma_pkg::ACC_W-1:0]    init_next, init3, acc, acc_next;
  logic [bmma_pkg::ACC_W-bmma_pkg::C_W:0] acc_top;
  logic                          sat;
  logic [bmma_pkg::C_W-1:0]      sat_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag   <= '0;
      s2_tag   <= '0;
      s3_tag   <= '0;
      s4_valid <= 1'b0;
    end else begin
      s1_tag   <= tag_in;
      s2_tag   <= s1_tag;
      s3_tag   <= s2_tag;
      s4_valid <= s3_tag.valid && s3_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    prod2   <= $signed(a_q) * $signed(b_q);
    cprod2  <= $signed(c_q) * $signed(beta_value);
    c2      <= c_q;
    mark2   <= c_mark_q;
    prod3   <= prod2;
    init3   <= init_next;
    mark3   <= mark2;
    s4_cell <= s3_tag.idx;
    if (s3_tag.valid) begin
      acc <= acc_next;
    end
    if (s3_tag.valid && s3_tag.first) begin
      mark_hold <= mark3;
    end
  end

  // c*beta rounded half up from q.44 to q.30
  assign round_sum = cprod2 + bmma_pkg::CPROD_W'(bmma_pkg::ROUND_BIAS);
  assign scaled    = $signed(round_sum) >>> bmma_pkg::ROUND_SHIFT;

  always_comb begin
    unique case (beta_mode)
      bmma_pkg::BETA_ZERO: init_next = '0;
      bmma_pkg::BETA_KEEP: init_next = {{(bmma_pkg::ACC_W-bmma_pkg::C_W){c2[bmma_pkg::C_W-1]}}, c2};
      default:             init_next = scaled[bmma_pkg::ACC_W-1:0];
    endcase
  end

  assign acc_next = (s3_tag.first ? init3 : acc)
                  + {{(bmma_pkg::ACC_W-bmma_pkg::PROD_W){prod3[bmma_pkg::PROD_W-1]}}, prod3};

  // clamp to 48 bits when the upper bits are not a sign extension
  assign acc_top   = acc[bmma_pkg::ACC_W-1:bmma_pkg::C_W-1];
  assign sat       = !((&acc_top) || !(|acc_top));
  assign sat_value = acc[bmma_pkg::ACC_W-1] ? {1'b1, {(bmma_pkg::C_W-1){1'b0}}}
                                            : {1'b0, {(bmma_pkg::C_W-1){1'b1}}};

  always_comb begin
    wb.en    = s4_valid;
    wb.addr  = s4_cell;
    wb.value = sat ? sat_value : acc[bmma_pkg::C_W-1:0];
    wb.mark  = (beta_mode == bmma_pkg::BETA_ZERO) ? sat : (mark_hold | sat);
    wb_sat   = s4_valid & sat;
  end

endmodule

// File: tb/sv/testbench.sv
// testbench for the block matrix multiply-accumulate: shadow predictor, bursty driver, monitor
`timescale 1ns / 1ps
module testbench;

  // unused operation codes, the block must ignore them
  localparam logic [bmma_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [bmma_pkg::OP_W-1:0] OP_UNUSED_LAST  = {bmma_pkg::OP_W{1'b1}};
  // mode three behaves like general scaling
  localparam logic [bmma_pkg::MODE_W-1:0] BETA_SCALE_ALIAS = 2'd3;

  localparam logic signed [bmma_pkg::BETA_W-1:0] BETA_MOST_NEG = 16'sh8000;
  localparam logic signed [bmma_pkg::BETA_W-1:0] BETA_MOST_POS = 16'sh7FFF;
  localparam logic signed [bmma_pkg::OPND_W-1:0] OPND_MOST_NEG = 16'sh8000;
  localparam logic signed [bmma_pkg::OPND_W-1:0] OPND_MOST_POS = 16'sh7FFF;

  localparam longint ACC_MAX = (longint'(1) <<< (bmma_pkg::C_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_REQUESTS  = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_READS  = 12;
  // a write leaves no result, so the block is given a settling wait after the last one
  localparam int SETTLE_CYCLES   = 16;
  // a run is a full issue pass plus drain; the limit covers every run plus bursty traffic
  localparam int CYCLE_LIMIT     = 2_000_000;

  typedef struct packed {
    logic [bmma_pkg::OP_W-1:0]          op;
    logic [bmma_pkg::FI_W-1:0]          fi;
    logic [bmma_pkg::SI_W-1:0]          si;
    logic signed [bmma_pkg::OPND_W-1:0] operand;
    logic signed [bmma_pkg::C_W-1:0]    acc;
  } request_t;

  typedef struct packed {
    logic                            kind;
    logic signed [bmma_pkg::C_W-1:0] value;
    logic                            sat;
  } result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [bmma_pkg::ADDR_W-1:0]        paddr = '0;
  logic [bmma_pkg::DATA_W-1:0]        pwdata = '0;
  logic [bmma_pkg::DATA_W-1:0]        prdata;
  logic                               pready;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [bmma_pkg::OP_W-1:0]          operation = '0;
  logic [bmma_pkg::FI_W-1:0]          first_index = '0;
  logic [bmma_pkg::SI_W-1:0]          second_index = '0;
  logic signed [bmma_pkg::OPND_W-1:0] operand = '0;
  logic signed [bmma_pkg::C_W-1:0]    acc_value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               result_kind;
  logic signed [bmma_pkg::C_W-1:0]    result_value;
  logic                               saturated;

  block_matrix_multiply_accumulate dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .first_index  (first_index),
    .second_index (second_index),
    .operand      (operand),
    .acc_value    (acc_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .result_value (result_value),
    .saturated    (saturated)
  );

  // shadow copy of the block: stores, saturation marks and registers
  logic signed [bmma_pkg::OPND_W-1:0] a_mirror [bmma_pkg::BLOCK_ROWS*bmma_pkg::BLOCK_DEPTH];
  logic signed [bmma_pkg::OPND_W-1:0] b_mirror [bmma_pkg::BLOCK_COLS*bmma_pkg::BLOCK_DEPTH];
  logic signed [bmma_pkg::C_W-1:0]    c_mirror [bmma_pkg::CELLS];
  logic                               mark_mirror [bmma_pkg::CELLS];
  logic [bmma_pkg::MODE_W-1:0]        mode_mirror;
  logic signed [bmma_pkg::BETA_W-1:0] beta_mirror;

  request_t pending_requests [$];
  result_t  awaited_results [$];
  request_t current_request;
  result_t  oldest_result;

  int error_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int run_count = 0;
  int saturated_runs = 0;
  int config_count = 0;
  int cycle_count = 0;
  int hold_off_asks = 0;

  // block pass: C = base + A*transpose(B), base 0, C or beta*C by mode; entries saturated once
  function automatic logic run_block_gemm();
    logic   any_sat;
    logic   sat;
    longint acc;
    int     entry;
    any_sat = 1'b0;
    for (int i = 0; i < bmma_pkg::BLOCK_ROWS; i++) begin
      for (int j = 0; j < bmma_pkg::BLOCK_COLS; j++) begin
        entry = i * bmma_pkg::BLOCK_COLS + j;
        case (mode_mirror)
          bmma_pkg::BETA_ZERO: acc = 0;
          bmma_pkg::BETA_KEEP: acc = longint'(c_mirror[entry]);
          // scale and mode three both round the Q.44 product half up
          default: acc = (longint'(c_mirror[entry]) * longint'(beta_mirror)
                          + longint'(bmma_pkg::ROUND_BIAS)) >>> bmma_pkg::ROUND_SHIFT;
        endcase
        for (int k = 0; k < bmma_pkg::BLOCK_DEPTH; k++)
          acc += longint'(a_mirror[i*bmma_pkg::BLOCK_DEPTH + k])
               * longint'(b_mirror[j*bmma_pkg::BLOCK_DEPTH + k]);
        sat = 1'b0;
        if (acc > ACC_MAX) begin
          acc = ACC_MAX;
          sat = 1'b1;
        end else if (acc < ACC_MIN) begin
          acc = ACC_MIN;
          sat = 1'b1;
        end
        c_mirror[entry] = acc[bmma_pkg::C_W-1:0];
        // clear-first mode recomputes the mark, the others only add to it
        if (mode_mirror == bmma_pkg::BETA_ZERO) mark_mirror[entry] = sat;
        else mark_mirror[entry] = mark_mirror[entry] | sat;
        any_sat = any_sat | sat;
      end
    end
    return any_sat;
  endfunction

  // update the shadow for one accepted request and queue the result it causes
  function automatic void absorb_request(request_t req);
    result_t res;
    case (req.op)
      bmma_pkg::OP_WRITE_A:
        if (req.fi < bmma_pkg::BLOCK_ROWS && req.si < bmma_pkg::BLOCK_DEPTH)
          a_mirror[req.fi*bmma_pkg::BLOCK_DEPTH + req.si] = req.operand;
      bmma_pkg::OP_WRITE_B:
        if (req.fi < bmma_pkg::BLOCK_COLS && req.si < bmma_pkg::BLOCK_DEPTH)
          b_mirror[req.fi*bmma_pkg::BLOCK_DEPTH + req.si] = req.operand;
      bmma_pkg::OP_WRITE_C:
        if (req.fi < bmma_pkg::BLOCK_ROWS && req.si < bmma_pkg::BLOCK_COLS) begin
          c_mirror[req.fi*bmma_pkg::BLOCK_COLS + req.si] = req.acc;
          mark_mirror[req.fi*bmma_pkg::BLOCK_COLS + req.si] = 1'b0;
        end
      bmma_pkg::OP_RUN: begin
        res.kind = bmma_pkg::KIND_RUN;
        res.value = '0;
        res.sat = run_block_gemm();
        awaited_results.push_back(res);
      end
      bmma_pkg::OP_READ_C: begin
        res.kind = bmma_pkg::KIND_READ;
        // a column past the block reads as zero with no mark
        if (req.fi < bmma_pkg::BLOCK_ROWS && req.si < bmma_pkg::BLOCK_COLS) begin
          res.value = c_mirror[req.fi*bmma_pkg::BLOCK_COLS + req.si];
          res.sat = mark_mirror[req.fi*bmma_pkg::BLOCK_COLS + req.si];
        end else begin
          res.value = '0;
          res.sat = 1'b0;
        end
        awaited_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // codes and indexes come in as plain numbers and are cut to their field widths here
  function automatic void queue_request(int op, int fi, int si,
                                        logic signed [bmma_pkg::OPND_W-1:0] opnd,
                                        logic signed [bmma_pkg::C_W-1:0] acc);
    request_t req;
    req.op = bmma_pkg::OP_W'(op);
    req.fi = bmma_pkg::FI_W'(fi);
    req.si = bmma_pkg::SI_W'(si);
    req.operand = opnd;
    req.acc = acc;
    pending_requests.push_back(req);
  endfunction

  // operands lean toward the extremes now and then
  function automatic logic signed [bmma_pkg::OPND_W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0: return OPND_MOST_NEG;
      1: return OPND_MOST_POS;
      2: return '0;
      default: return bmma_pkg::OPND_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [bmma_pkg::C_W-1:0] random_acc();
    case ($urandom_range(0, 7))
      0: return ACC_MAX[bmma_pkg::C_W-1:0];
      1: return ACC_MIN[bmma_pkg::C_W-1:0];
      2: return '0;
      default: return bmma_pkg::C_W'({$urandom, $urandom});
    endcase
  endfunction

  // register port: setup cycle, then access until pready
  task automatic reg_access(input logic idx, input logic wr,
                            input logic [bmma_pkg::DATA_W-1:0] wdata,
                            output logic [bmma_pkg::DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= bmma_pkg::ADDR_W'(idx) << bmma_pkg::REG_SEL_BIT;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_config(input logic [bmma_pkg::MODE_W-1:0] mode,
                              input logic [bmma_pkg::BETA_W-1:0] beta);
    logic [bmma_pkg::DATA_W-1:0] rd;
    reg_access(bmma_pkg::REG_BETA_MODE, 1'b0, '0, rd);
    if (rd[bmma_pkg::MODE_W-1:0] !== mode) begin
      $error("beta_mode expected %0d got %0d", mode, rd[bmma_pkg::MODE_W-1:0]);
      error_count++;
    end
    reg_access(bmma_pkg::REG_BETA_VALUE, 1'b0, '0, rd);
    if (rd[bmma_pkg::BETA_W-1:0] !== beta) begin
      $error("beta_value expected %0h got %0h", beta, rd[bmma_pkg::BETA_W-1:0]);
      error_count++;
    end
  endtask

  task automatic set_config(input logic [bmma_pkg::MODE_W-1:0] mode,
                            input logic [bmma_pkg::BETA_W-1:0] beta);
    logic [bmma_pkg::DATA_W-1:0] unused;
    reg_access(bmma_pkg::REG_BETA_MODE, 1'b1, bmma_pkg::DATA_W'(mode), unused);
    reg_access(bmma_pkg::REG_BETA_VALUE, 1'b1,
               {{(bmma_pkg::DATA_W-bmma_pkg::BETA_W){beta[bmma_pkg::BETA_W-1]}}, beta}, unused);
    mode_mirror = mode;
    beta_mirror = beta;
    config_count++;
    check_config(mode, beta);
  endtask

  // block is idle once nothing waits to go in, nothing is on the wires and nothing is owed
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver: bursts of random length with random gaps, holds while stalled
  int   burst_left = 0;
  int   gap_left = 0;
  logic next_valid;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request(current_request);
        accepted_count++;
      end
      // a stalled request stays on the wires untouched
      if (!(in_valid && in_stall)) begin
        next_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          current_request = pending_requests.pop_front();
          next_valid = 1'b1;
          operation <= current_request.op;
          first_index <= current_request.fi;
          second_index <= current_request.si;
          operand <= current_request.operand;
          acc_value <= current_request.acc;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // result stall: phases of random length and density, plus long hold-offs on request
  int   hold_off_seen = 0;
  int   hold_off_left = 0;
  int   stall_phase_left = 0;
  int   stall_pct = 0;
  logic next_stall;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_off_left != 0) begin
        hold_off_left--;
        next_stall = 1'b1;
      end else if (hold_off_asks != hold_off_seen) begin
        hold_off_seen = hold_off_asks;
        hold_off_left = HOLD_OFF_CYCLES;
        next_stall = 1'b1;
      end else begin
        if (stall_phase_left == 0) begin
          stall_phase_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        stall_phase_left--;
        next_stall = ($urandom_range(0, 99) < stall_pct);
      end
      out_stall <= next_stall;
    end
  end

  // result monitor: field by field against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d value %0d saturated %0d",
               result_kind, result_value, saturated);
        error_count++;
      end else begin
        oldest_result = awaited_results.pop_front();
        result_count++;
        if (result_kind !== oldest_result.kind) begin
          $error("result_kind expected %0d got %0d", oldest_result.kind, result_kind);
          error_count++;
        end
        if (result_value !== oldest_result.value) begin
          $error("result_value expected %0d got %0d", oldest_result.value, result_value);
          error_count++;
        end
        if (saturated !== oldest_result.sat) begin
          $error("saturated expected %0d got %0d", oldest_result.sat, saturated);
          error_count++;
        end
        if (oldest_result.kind == bmma_pkg::KIND_RUN) begin
          run_count++;
          if (oldest_result.sat) saturated_runs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus sequence
  int pick;
  logic [bmma_pkg::SI_W-1:0] col;

  initial begin
    mode_mirror = bmma_pkg::BETA_SCALE;
    beta_mirror = bmma_pkg::BETA_ONE;
    for (int c = 0; c < bmma_pkg::CELLS; c++) mark_mirror[c] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values of the registers
    check_config(bmma_pkg::BETA_SCALE, bmma_pkg::BETA_ONE);

    // directed: C extremes written and read back, columns past the block, unused codes
    queue_request(bmma_pkg::OP_WRITE_C, 0, 0, random_operand(), ACC_MAX[bmma_pkg::C_W-1:0]);
    queue_request(bmma_pkg::OP_WRITE_C, bmma_pkg::BLOCK_ROWS-1, bmma_pkg::BLOCK_COLS-1,
                  random_operand(), ACC_MIN[bmma_pkg::C_W-1:0]);
    queue_request(bmma_pkg::OP_WRITE_C, 3, 5, random_operand(), '0);
    queue_request(bmma_pkg::OP_READ_C, 0, 0, random_operand(), random_acc());
    queue_request(bmma_pkg::OP_READ_C, bmma_pkg::BLOCK_ROWS-1, bmma_pkg::BLOCK_COLS-1,
                  random_operand(), random_acc());
    queue_request(bmma_pkg::OP_READ_C, 3, 5, random_operand(), random_acc());
    queue_request(bmma_pkg::OP_WRITE_C, bmma_pkg::BLOCK_ROWS-1, (1 << bmma_pkg::SI_W) - 1,
                  random_operand(), random_acc());
    queue_request(bmma_pkg::OP_WRITE_C, 0, bmma_pkg::BLOCK_COLS, random_operand(),
                  random_acc());
    queue_request(bmma_pkg::OP_READ_C, bmma_pkg::BLOCK_ROWS-1, (1 << bmma_pkg::SI_W) - 1,
                  random_operand(), random_acc());
    queue_request(bmma_pkg::OP_READ_C, 0, bmma_pkg::BLOCK_COLS, random_operand(),
                  random_acc());
    queue_request(bmma_pkg::OP_READ_C, 3, 5, random_operand(), random_acc());
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      queue_request(op, $urandom, $urandom, random_operand(), random_acc());

    // fill every store entry before any run; row 0 of A and B at the most negative
    // operand so C[0][0] gains 2^36 per run
    for (int i = 0; i < bmma_pkg::BLOCK_ROWS; i++)
      for (int k = 0; k < bmma_pkg::BLOCK_DEPTH; k++)
        queue_request(bmma_pkg::OP_WRITE_A, i, k, (i == 0) ? OPND_MOST_NEG : random_operand(),
                      random_acc());
    for (int j = 0; j < bmma_pkg::BLOCK_COLS; j++)
      for (int k = 0; k < bmma_pkg::BLOCK_DEPTH; k++)
        queue_request(bmma_pkg::OP_WRITE_B, j, k, (j == 0) ? OPND_MOST_NEG : random_operand(),
                      random_acc());
    for (int c = 0; c < bmma_pkg::CELLS; c++)
      queue_request(bmma_pkg::OP_WRITE_C, c / bmma_pkg::BLOCK_COLS, c % bmma_pkg::BLOCK_COLS,
                    random_operand(), (c == 0) ? ACC_MAX[bmma_pkg::C_W-1:0] : random_acc());

    // scale by one on a full C[0][0] must saturate and mark it
    queue_request(bmma_pkg::OP_RUN, 0, 0, random_operand(), random_acc());
    queue_request(bmma_pkg::OP_READ_C, 0, 0, random_operand(), random_acc());
    wait_idle();
    // clear-first mode drops the mark
    set_config(bmma_pkg::BETA_ZERO, BETA_MOST_NEG);
    queue_request(bmma_pkg::OP_RUN, 0, 0, random_operand(), random_acc());
    queue_request(bmma_pkg::OP_READ_C, 0, 0, random_operand(), random_acc());
    wait_idle();

    // random phases, one register setting each, extremes included
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_config(bmma_pkg::BETA_KEEP, bmma_pkg::BETA_ONE);
        1: set_config(bmma_pkg::BETA_SCALE, BETA_MOST_NEG);
        2: set_config(bmma_pkg::BETA_ZERO, '0);
        3: set_config(BETA_SCALE_ALIAS, BETA_MOST_POS);
        4: set_config(bmma_pkg::BETA_SCALE, '0);
        default: set_config(bmma_pkg::MODE_W'($urandom_range(0, 3)),
                            bmma_pkg::BETA_W'($urandom));
      endcase
      if (phase == 0) begin
        // back-to-back reads against a long result hold-off fill the block up
        for (int n = 0; n < HOLD_OFF_READS; n++)
          queue_request(bmma_pkg::OP_READ_C, $urandom, $urandom_range(0, bmma_pkg::BLOCK_COLS-1),
                        random_operand(), random_acc());
        hold_off_asks++;
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        // mostly in-block columns for C, now and then a random one that may lie past the edge
        col = bmma_pkg::SI_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                          : $urandom_range(0, bmma_pkg::BLOCK_COLS-1));
        if (pick < 4)
          queue_request($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST), $urandom, $urandom,
                        random_operand(), random_acc());
        else if (pick < 16)
          queue_request(bmma_pkg::OP_RUN, $urandom, $urandom, random_operand(), random_acc());
        else if (pick < 46)
          queue_request(bmma_pkg::OP_READ_C, $urandom, col, random_operand(), random_acc());
        else if (pick < 60)
          queue_request(bmma_pkg::OP_WRITE_C, $urandom, col, random_operand(), random_acc());
        else if (pick < 80)
          queue_request(bmma_pkg::OP_WRITE_A, $urandom, $urandom, random_operand(),
                        random_acc());
        else
          queue_request(bmma_pkg::OP_WRITE_B, $urandom, $urandom, random_operand(),
                        random_acc());
      end
      wait_idle();
    end

    $display("run covered %0d requests and %0d results over %0d register settings",
             accepted_count, result_count, config_count + 1);
    $display("block passes: %0d, of which %0d saturated at least one entry",
             run_count, saturated_runs);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
